### design/dcle_pkg.sv
// ============================================================================
// dcle_pkg
// Shared types and codes of the DHCP client lease engine: commands, reply
// kinds, result kinds, task phases, the slot entry and the result record.
// ============================================================================
`default_nettype none

package dcle_pkg;

    // Command codes of an input transaction
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_ADD   = 2'd2;

    // Reply kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;
    localparam logic [1:0] KIND_NAK   = 2'd3;

    // Result kinds
    localparam logic [1:0] RES_DISCOVER = 2'd0;
    localparam logic [1:0] RES_REQUEST  = 2'd1;
    localparam logic [1:0] RES_BOUND    = 2'd2;
    localparam logic [1:0] RES_ADD      = 2'd3;

    // Task phases
    localparam logic [1:0] PH_DISCOVER = 2'd0;
    localparam logic [1:0] PH_REQUEST  = 2'd1;
    localparam logic [1:0] PH_BOUND    = 2'd2;

    // First transaction identifier after reset
    localparam logic [31:0] XID_START = 32'h1000_0000;

    // Results reported per tick at most
    localparam int unsigned OUT_CAP = 8;
    localparam int unsigned NRES_W  = $clog2(OUT_CAP + 1);

    // One task slot
    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] countdown;
        logic [31:0] xid;
        logic [47:0] mac;
        logic [31:0] offer;
        logic [31:0] server;
    } t_entry;

    // Latched input transaction
    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] mac;
        logic        is_boot;
        logic [31:0] xid;
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] server;
        logic [31:0] router;
        logic [31:0] mask;
        logic [31:0] dns;
        logic [31:0] lease;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  slot;
        logic [47:0] mac;
        logic [31:0] xid;
        logic [31:0] addr;
        logic [31:0] server;
        logic [31:0] gw;
        logic [31:0] mask;
        logic [31:0] dns;
        logic [31:0] bcast;
        logic        add_ok;
        logic        last;
    } t_result;

    // Control from the slot unit to the sequencer
    typedef struct packed {
        logic wr;         // write the updated entry back
        logic hit;        // reply identifier matches this slot
        logic res_valid;  // slot produces a result
        logic xid_bump;   // slot took next_xid, advance it
    } t_slot_ctl;

endpackage

`default_nettype wire

### design/dcle_slot_unit.sv
// ============================================================================
// dcle_slot_unit
// Update of one task slot for a tick or a reply, built around one shared
// 32-bit adder that either counts the countdown down or advances next_xid.
// ============================================================================
`default_nettype none

module dcle_slot_unit #(
    parameter int unsigned RETRY_TICKS = 3
) (
    input  wire                 i_tick,
    input  wire dcle_pkg::t_entry i_entry,
    input  wire dcle_pkg::t_item  i_item,
    input  wire  [31:0]         i_next_xid,
    input  wire  [2:0]          i_slot,
    output dcle_pkg::t_entry    o_entry,
    output dcle_pkg::t_slot_ctl o_ctl,
    output dcle_pkg::t_result   o_result,
    output logic [31:0]         o_sum
);

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        cd_zero;

    assign cd_zero = (i_entry.countdown == 32'd0);

    // Shared adder: decrement the countdown, or increment next_xid
    always_comb begin
        if (!cd_zero) begin
            op_a = i_entry.countdown;
            op_b = '1;
        end else begin
            op_a = i_next_xid;
            op_b = 32'd1;
        end
    end

    assign o_sum = op_a + op_b;

    // Slot update and result
    always_comb begin
        o_entry       = i_entry;
        o_ctl         = '0;
        o_result      = '0;
        o_result.slot = i_slot;
        o_result.mac  = i_entry.mac;
        o_result.xid  = i_entry.xid;
        if (i_tick) begin
            if (!cd_zero) begin
                o_entry.countdown = o_sum;
                o_ctl.wr          = 1'b1;
            end else begin
                case (i_entry.phase)
                    dcle_pkg::PH_DISCOVER: begin
                        o_result.kind     = dcle_pkg::RES_DISCOVER;
                        o_ctl.res_valid   = 1'b1;
                        o_entry.countdown = 32'(RETRY_TICKS);
                        o_ctl.wr          = 1'b1;
                    end
                    dcle_pkg::PH_REQUEST: begin
                        o_result.kind     = dcle_pkg::RES_REQUEST;
                        o_result.addr     = i_entry.offer;
                        o_result.server   = i_entry.server;
                        o_ctl.res_valid   = 1'b1;
                        o_entry.countdown = 32'(RETRY_TICKS);
                        o_ctl.wr          = 1'b1;
                    end
                    default: begin
                        // lease ran out: restart discovery with a fresh id
                        o_entry.phase     = dcle_pkg::PH_DISCOVER;
                        o_entry.xid       = i_next_xid;
                        o_entry.countdown = 32'd0;
                        o_ctl.wr          = 1'b1;
                        o_ctl.xid_bump    = 1'b1;
                    end
                endcase
            end
        end else if (i_entry.xid == i_item.xid) begin
            o_ctl.hit = 1'b1;
            case (i_item.kind)
                dcle_pkg::KIND_OFFER: begin
                    o_entry.offer     = i_item.addr;
                    o_entry.server    = i_item.server;
                    o_entry.phase     = dcle_pkg::PH_REQUEST;
                    o_entry.countdown = 32'd0;
                    o_ctl.wr          = 1'b1;
                end
                dcle_pkg::KIND_ACK: begin
                    o_entry.phase     = dcle_pkg::PH_BOUND;
                    o_entry.countdown = i_item.lease;
                    o_ctl.wr          = 1'b1;
                    o_ctl.res_valid   = 1'b1;
                    o_result.kind     = dcle_pkg::RES_BOUND;
                    o_result.addr     = i_item.addr;
                    o_result.gw       = i_item.router;
                    o_result.mask     = i_item.mask;
                    o_result.dns      = i_item.dns;
                    o_result.bcast    = (i_item.addr & i_item.mask) | ~i_item.mask;
                end
                dcle_pkg::KIND_NAK: begin
                    o_entry.phase     = dcle_pkg::PH_DISCOVER;
                    o_entry.countdown = 32'd0;
                    o_ctl.wr          = 1'b1;
                end
                default: begin
                    // matched, nothing changes
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/dhcp_client_lease_engine.sv
// ============================================================================
// dhcp_client_lease_engine
// Table of DHCP client tasks stepped by add, reply and one second tick
// transactions; reports messages to send and bound address sets.
// ============================================================================
// Usage:
//   Input channel i_valid/o_ready carries one command per transaction: a
//   tick, a received reply or an add. Output channel o_valid/i_ready carries
//   result transactions; o_last marks the final result of a command.
//   Slots are claimed in order and never released, so a fill count tracks
//   use and newest first means highest slot first.
//   An add claims the next free slot, then hands over its result. A tick or
//   a reply walks the used slots from newest to oldest, each slot by a
//   memory read, then update and write back through the shared slot unit,
//   and then hands over the last result.
//   One command is worked at a time; o_ready is high only between commands.
//   A tick holds up to two results (one pending, one in the output
//   register); when the receiver stalls, the walk waits on the next result.
//   Ticks report at most eight results; later slots still update.
//   Reset empties the table and sets the next identifier to 0x10000000;
//   no clearing pass is needed.
// ============================================================================
`default_nettype none

module dhcp_client_lease_engine #(
    parameter int unsigned MAX_TASKS   = 8,
    parameter int unsigned RETRY_TICKS = 3
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_command,
    input  wire  [47:0] i_client_mac_in,
    input  wire         i_is_boot_reply,
    input  wire  [31:0] i_reply_xid,
    input  wire  [1:0]  i_reply_kind,
    input  wire  [31:0] i_offered_addr,
    input  wire  [31:0] i_server_id_in,
    input  wire  [31:0] i_router_addr,
    input  wire  [31:0] i_mask_in,
    input  wire  [31:0] i_dns_in,
    input  wire  [31:0] i_lease_ticks,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_slot_index,
    output logic [47:0] o_client_mac_out,
    output logic [31:0] o_transaction_id,
    output logic [31:0] o_address_out,
    output logic [31:0] o_server_out,
    output logic [31:0] o_gateway_out,
    output logic [31:0] o_mask_out,
    output logic [31:0] o_dns_out,
    output logic [31:0] o_broadcast_out,
    output logic        o_add_ok,
    output logic        o_last
);

    localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TASKS + 1);
    localparam int unsigned XW = (IW > 3) ? IW : 3;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ADD   = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EXEC  = 5'b01000,
        ST_FLUSH = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [31:0]                     r_next_xid, n_next_xid;
    logic [IW-1:0]                   r_idx, n_idx;
    logic [dcle_pkg::NRES_W-1:0]     r_nres, n_nres;
    dcle_pkg::t_item                 r_in, n_in;
    dcle_pkg::t_result               r_pend, n_pend;
    logic                            r_pend_valid, n_pend_valid;
    dcle_pkg::t_result               r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    dcle_pkg::t_entry                r_mem [MAX_TASKS];
    dcle_pkg::t_entry                r_rdata;
    logic                            wr_en;
    logic [IW-1:0]                   wr_addr;
    dcle_pkg::t_entry                wr_data;

    dcle_pkg::t_entry                upd_entry;
    dcle_pkg::t_slot_ctl             upd_ctl;
    dcle_pkg::t_result               upd_result;
    logic [31:0]                     upd_sum;

    logic [XW-1:0]                   idx_ext;
    logic [XW-1:0]                   cnt_ext;
    logic                            is_tick;
    logic                            out_free;
    logic                            need;
    logic                            stall;

    assign idx_ext  = XW'(r_idx);
    assign cnt_ext  = XW'(IW'(r_count));
    assign is_tick  = (r_in.cmd == dcle_pkg::CMD_TICK);
    assign out_free = !r_out_valid || i_ready;

    // Per-slot update through the shared unit
    dcle_slot_unit #(
        .RETRY_TICKS (RETRY_TICKS)
    ) u_slot (
        .i_tick     (is_tick),
        .i_entry    (r_rdata),
        .i_item     (r_in),
        .i_next_xid (r_next_xid),
        .i_slot     (idx_ext[2:0]),
        .o_entry    (upd_entry),
        .o_ctl      (upd_ctl),
        .o_result   (upd_result),
        .o_sum      (upd_sum)
    );

    // Slot table: one write port, registered read at the walk index
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[r_idx];
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_next_xid   = r_next_xid;
        n_idx        = r_idx;
        n_nres       = r_nres;
        n_in         = r_in;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_ready;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = upd_entry;
        need         = upd_ctl.res_valid && (r_nres < dcle_pkg::NRES_W'(dcle_pkg::OUT_CAP));
        stall        = need && r_pend_valid && !out_free;
        case (r_state)
            ST_IDLE: begin
                // take a new command and pick the walk start
                if (i_valid) begin
                    n_in.cmd     = i_command;
                    n_in.mac     = i_client_mac_in;
                    n_in.is_boot = i_is_boot_reply;
                    n_in.xid     = i_reply_xid;
                    n_in.kind    = i_reply_kind;
                    n_in.addr    = i_offered_addr;
                    n_in.server  = i_server_id_in;
                    n_in.router  = i_router_addr;
                    n_in.mask    = i_mask_in;
                    n_in.dns     = i_dns_in;
                    n_in.lease   = i_lease_ticks;
                    n_nres       = '0;
                    n_pend_valid = 1'b0;
                    n_idx        = IW'(r_count - CW'(1));
                    case (i_command)
                        dcle_pkg::CMD_ADD: begin
                            n_state = ST_ADD;
                        end
                        dcle_pkg::CMD_TICK: begin
                            if (r_count != '0) begin
                                n_state = ST_READ;
                            end
                        end
                        dcle_pkg::CMD_REPLY: begin
                            if (r_count != '0 && i_is_boot_reply) begin
                                n_state = ST_READ;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD: begin
                // claim the next free slot, or report a full table
                n_pend      = '0;
                n_pend.kind = dcle_pkg::RES_ADD;
                if (r_count != CW'(MAX_TASKS)) begin
                    wr_en             = 1'b1;
                    wr_addr           = IW'(r_count);
                    wr_data           = '0;
                    wr_data.phase     = dcle_pkg::PH_DISCOVER;
                    wr_data.xid       = r_next_xid;
                    wr_data.mac       = r_in.mac;
                    n_count           = r_count + CW'(1);
                    n_next_xid        = r_next_xid + 32'd1;
                    n_pend.slot       = cnt_ext[2:0];
                    n_pend.mac        = r_in.mac;
                    n_pend.xid        = r_next_xid;
                    n_pend.add_ok     = 1'b1;
                end
                n_pend_valid = 1'b1;
                n_state      = ST_FLUSH;
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                // update the slot; hold while a result cannot be placed
                if (!stall) begin
                    wr_en = upd_ctl.wr;
                    if (upd_ctl.xid_bump) begin
                        n_next_xid = upd_sum;
                    end
                    if (need) begin
                        if (r_pend_valid) begin
                            n_out       = r_pend;
                            n_out_valid = 1'b1;
                        end
                        n_pend       = upd_result;
                        n_pend_valid = 1'b1;
                        n_nres       = r_nres + dcle_pkg::NRES_W'(1);
                    end
                    if ((!is_tick && upd_ctl.hit) || r_idx == '0) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx   = r_idx - IW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_FLUSH: begin
                // hand over the final result marked last
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out        = r_pend;
                    n_out.last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_next_xid   <= dcle_pkg::XID_START;
            r_nres       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_next_xid   <= n_next_xid;
            r_nres       <= n_nres;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_in   <= n_in;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    // Drive ports
    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_slot_index     = r_out.slot;
    assign o_client_mac_out = r_out.mac;
    assign o_transaction_id = r_out.xid;
    assign o_address_out    = r_out.addr;
    assign o_server_out     = r_out.server;
    assign o_gateway_out    = r_out.gw;
    assign o_mask_out       = r_out.mask;
    assign o_dns_out        = r_out.dns;
    assign o_broadcast_out  = r_out.bcast;
    assign o_add_ok         = r_out.add_ok;
    assign o_last           = r_out.last;

endmodule

`default_nettype wire

### sim/dhcp_client_lease_engine_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// dhcp_client_lease_engine_tb
// Drives add, reply and tick commands into the lease engine under random
// idling on both channels. A local copy of the task table predicts every
// discover, request, bound and add outcome, and each result is checked
// field by field in order.
// ============================================================================

module dhcp_client_lease_engine_tb;

    localparam int          NSLOTS      = 8;
    localparam int          RETRY_TICKS = 3;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          MAX_IDLE    = 18;
    localparam int          DRAIN_WAIT  = 40;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              out_ready;
    dcle_pkg::t_item   drv;

    logic        res_valid;
    logic [1:0]  res_kind;
    logic [2:0]  res_slot;
    logic [47:0] res_mac;
    logic [31:0] res_xid;
    logic [31:0] res_addr;
    logic [31:0] res_server;
    logic [31:0] res_gw;
    logic [31:0] res_mask;
    logic [31:0] res_dns;
    logic [31:0] res_bcast;
    logic        res_add_ok;
    logic        res_last;

    // Local copy of the task table
    logic        used_q  [NSLOTS];
    logic [1:0]  phase_q [NSLOTS];
    logic [31:0] cnt_q   [NSLOTS];
    logic [31:0] xid_q   [NSLOTS];
    logic [47:0] mac_q   [NSLOTS];
    logic [31:0] offer_q [NSLOTS];
    logic [31:0] srv_q   [NSLOTS];
    int unsigned age_q   [NSLOTS];
    logic [31:0] xid_next;

    dcle_pkg::t_result lease_msgs_q[$];

    bit          idle_en;
    int          ready_wait;
    int          mismatches;
    int          cmds_sent;
    int          noise_sent;
    int          results_seen;
    int          kind_seen[4];

    dhcp_client_lease_engine #(
        .MAX_TASKS   (NSLOTS),
        .RETRY_TICKS (RETRY_TICKS)
    ) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_command        (drv.cmd),
        .i_client_mac_in  (drv.mac),
        .i_is_boot_reply  (drv.is_boot),
        .i_reply_xid      (drv.xid),
        .i_reply_kind     (drv.kind),
        .i_offered_addr   (drv.addr),
        .i_server_id_in   (drv.server),
        .i_router_addr    (drv.router),
        .i_mask_in        (drv.mask),
        .i_dns_in         (drv.dns),
        .i_lease_ticks    (drv.lease),
        .o_valid          (res_valid),
        .i_ready          (out_ready),
        .o_result_kind    (res_kind),
        .o_slot_index     (res_slot),
        .o_client_mac_out (res_mac),
        .o_transaction_id (res_xid),
        .o_address_out    (res_addr),
        .o_server_out     (res_server),
        .o_gateway_out    (res_gw),
        .o_mask_out       (res_mask),
        .o_dns_out        (res_dns),
        .o_broadcast_out  (res_bcast),
        .o_add_ok         (res_add_ok),
        .o_last           (res_last)
    );

    // Clock: 20 ns period
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic dcle_pkg::t_result make_msg(logic [1:0] kind, int slot,
                                                   logic [47:0] mac,
                                                   logic [31:0] xid, logic [31:0] addr,
                                                   logic [31:0] server, logic [31:0] gw,
                                                   logic [31:0] mask, logic [31:0] dns,
                                                   logic [31:0] bcast, logic ok);
        dcle_pkg::t_result m;
        m.kind   = kind;
        m.slot   = 3'(slot);
        m.mac    = mac;
        m.xid    = xid;
        m.addr   = addr;
        m.server = server;
        m.gw     = gw;
        m.mask   = mask;
        m.dns    = dns;
        m.bcast  = bcast;
        m.add_ok = ok;
        m.last   = 1'b0;
        return m;
    endfunction

    // Find the slot holding a given newest-first rank
    function automatic int slot_at_age(int unsigned rank);
        int s;
        s = -1;
        for (int i = 0; i < NSLOTS; i++) begin
            if (used_q[i] && age_q[i] == rank && s < 0) s = i;
        end
        return s;
    endfunction

    // Advance the table by one command and queue the messages it causes
    function automatic void step_lease_table(input dcle_pkg::t_item it);
        int                 free_s;
        int                 hit;
        int                 s;
        dcle_pkg::t_result  batch[$];
        free_s = -1;
        hit    = -1;
        case (it.cmd)
            dcle_pkg::CMD_ADD: begin
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!used_q[i] && free_s < 0) free_s = i;
                end
                if (free_s < 0) begin
                    batch.push_back(make_msg(dcle_pkg::RES_ADD, 0, '0, '0, '0, '0, '0,
                                             '0, '0, '0, 1'b0));
                end else begin
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (used_q[i]) age_q[i]++;
                    end
                    used_q[free_s]  = 1'b1;
                    age_q[free_s]   = 0;
                    phase_q[free_s] = dcle_pkg::PH_DISCOVER;
                    cnt_q[free_s]   = '0;
                    mac_q[free_s]   = it.mac;
                    xid_q[free_s]   = xid_next;
                    offer_q[free_s] = '0;
                    srv_q[free_s]   = '0;
                    xid_next        = xid_next + 32'd1;
                    batch.push_back(make_msg(dcle_pkg::RES_ADD, free_s, mac_q[free_s],
                                             xid_q[free_s], '0, '0, '0, '0, '0, '0,
                                             1'b1));
                end
            end
            dcle_pkg::CMD_REPLY: begin
                // Match newest first; only boot replies count
                if (it.is_boot) begin
                    for (int r = 0; r < NSLOTS; r++) begin
                        s = slot_at_age(r);
                        if (hit < 0 && s >= 0 && xid_q[s] == it.xid) hit = s;
                    end
                end
                if (hit >= 0) begin
                    case (it.kind)
                        dcle_pkg::KIND_OFFER: begin
                            offer_q[hit] = it.addr;
                            srv_q[hit]   = it.server;
                            phase_q[hit] = dcle_pkg::PH_REQUEST;
                            cnt_q[hit]   = '0;
                        end
                        dcle_pkg::KIND_ACK: begin
                            phase_q[hit] = dcle_pkg::PH_BOUND;
                            cnt_q[hit]   = it.lease;
                            batch.push_back(make_msg(dcle_pkg::RES_BOUND, hit, mac_q[hit],
                                                     xid_q[hit], it.addr, '0, it.router,
                                                     it.mask, it.dns,
                                                     (it.addr & it.mask) | ~it.mask,
                                                     1'b0));
                        end
                        dcle_pkg::KIND_NAK: begin
                            phase_q[hit] = dcle_pkg::PH_DISCOVER;
                            cnt_q[hit]   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            dcle_pkg::CMD_TICK: begin
                for (int r = 0; r < NSLOTS; r++) begin
                    s = slot_at_age(r);
                    if (s >= 0) begin
                        if (cnt_q[s] != 0) begin
                            cnt_q[s] = cnt_q[s] - 32'd1;
                        end else if (phase_q[s] == dcle_pkg::PH_DISCOVER) begin
                            if (batch.size() < dcle_pkg::OUT_CAP)
                                batch.push_back(make_msg(dcle_pkg::RES_DISCOVER, s,
                                                         mac_q[s], xid_q[s], '0, '0, '0,
                                                         '0, '0, '0, 1'b0));
                            cnt_q[s] = RETRY_TICKS;
                        end else if (phase_q[s] == dcle_pkg::PH_REQUEST) begin
                            if (batch.size() < dcle_pkg::OUT_CAP)
                                batch.push_back(make_msg(dcle_pkg::RES_REQUEST, s,
                                                         mac_q[s], xid_q[s], offer_q[s],
                                                         srv_q[s], '0, '0, '0, '0,
                                                         1'b0));
                            cnt_q[s] = RETRY_TICKS;
                        end else begin
                            // Lease ran out: restart discovery with a fresh identifier
                            phase_q[s] = dcle_pkg::PH_DISCOVER;
                            xid_q[s]   = xid_next;
                            xid_next   = xid_next + 32'd1;
                            cnt_q[s]   = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) lease_msgs_q.push_back(batch[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Command builders
    // ------------------------------------------------------------------------

    function automatic dcle_pkg::t_item rand_item();
        dcle_pkg::t_item it;
        it.cmd     = 2'($urandom_range(3, 0));
        it.mac     = {16'($urandom), 32'($urandom)};
        it.is_boot = 1'($urandom);
        it.xid     = $urandom;
        it.kind    = 2'($urandom_range(3, 0));
        it.addr    = $urandom;
        it.server  = $urandom;
        it.router  = $urandom;
        it.mask    = $urandom;
        it.dns     = $urandom;
        it.lease   = $urandom;
        return it;
    endfunction

    function automatic dcle_pkg::t_item tick_item();
        dcle_pkg::t_item it;
        it     = rand_item();
        it.cmd = dcle_pkg::CMD_TICK;
        return it;
    endfunction

    function automatic dcle_pkg::t_item add_item(logic [47:0] mac);
        dcle_pkg::t_item it;
        it     = rand_item();
        it.cmd = dcle_pkg::CMD_ADD;
        it.mac = mac;
        return it;
    endfunction

    function automatic dcle_pkg::t_item reply_item(logic boot, logic [31:0] xid,
                                                   logic [1:0] kind);
        dcle_pkg::t_item it;
        it         = rand_item();
        it.cmd     = dcle_pkg::CMD_REPLY;
        it.is_boot = boot;
        it.xid     = xid;
        it.kind    = kind;
        it.lease   = $urandom_range(6, 0);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------------

    // Send one command transaction and update the table once it is taken
    task automatic send_item(input dcle_pkg::t_item it);
        int gap;
        gap = idle_en ? $urandom_range(MAX_IDLE, 0) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        drv      <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        step_lease_table(it);
        cmds_sent++;
    endtask

    // Drop valid and hold off until every expected result has arrived
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lease_msgs_q.size() != 0) @(posedge clk);
    endtask

    // Receiver stall: low for the drawn number of cycles after each result
    always @(negedge clk) begin
        out_ready <= (ready_wait == 0);
    end

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] seen_v);
        if (want_v !== seen_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %0s wrong: expected %0h, got %0h", $realtime, name,
                         want_v, seen_v);
        end
    endtask

    // Check each result transaction against the oldest expected message
    always @(posedge clk) begin
        dcle_pkg::t_result want;
        if (ready_wait > 0) ready_wait--;
        if (rst_n && res_valid && out_ready) begin
            ready_wait = idle_en ? $urandom_range(MAX_IDLE, 0) : 0;
            results_seen++;
            if (!$isunknown(res_kind)) kind_seen[res_kind]++;
            if (lease_msgs_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with none expected, kind %0h slot %0h",
                             $realtime, res_kind, res_slot);
            end else begin
                want = lease_msgs_q.pop_front();
                check_field("result_kind",    64'(want.kind),   64'(res_kind));
                check_field("slot_index",     64'(want.slot),   64'(res_slot));
                check_field("client_mac_out", 64'(want.mac),    64'(res_mac));
                check_field("transaction_id", 64'(want.xid),    64'(res_xid));
                check_field("address_out",    64'(want.addr),   64'(res_addr));
                check_field("server_out",     64'(want.server), 64'(res_server));
                check_field("gateway_out",    64'(want.gw),     64'(res_gw));
                check_field("mask_out",       64'(want.mask),   64'(res_mask));
                check_field("dns_out",        64'(want.dns),    64'(res_dns));
                check_field("broadcast_out",  64'(want.bcast),  64'(res_bcast));
                check_field("add_ok",         64'(want.add_ok), 64'(res_add_ok));
                check_field("last",           64'(want.last),   64'(res_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Empty table: everything but an add leaves it alone
    task automatic test_empty_table();
        dcle_pkg::t_item it;
        send_item(tick_item());
        send_item(reply_item(1'b1, $urandom, dcle_pkg::KIND_OFFER));
        it         = rand_item();
        it.cmd     = CMD_UNUSED;
        it.mac     = '1;
        it.is_boot = 1'b1;
        it.xid     = dcle_pkg::XID_START;
        it.kind    = dcle_pkg::KIND_ACK;
        send_item(it);
        send_item(reply_item(1'b0, dcle_pkg::XID_START, dcle_pkg::KIND_ACK));
    endtask

    // Claim every slot, then one add more than fits
    task automatic test_fill_table();
        send_item(add_item('0));
        send_item(add_item('1));
        repeat (NSLOTS - 2) send_item(add_item({16'($urandom), 32'($urandom)}));
        send_item(add_item({16'($urandom), 32'($urandom)}));
    endtask

    // Fresh tasks all send a discover, then count down
    task automatic test_discovery_ticks();
        send_item(tick_item());
        send_item(tick_item());
    endtask

    // Offers, acks, naks and other replies, with the lease running out
    task automatic test_reply_kinds();
        dcle_pkg::t_item it;
        logic [31:0]     stale_xid;
        it        = reply_item(1'b1, xid_q[NSLOTS - 1], dcle_pkg::KIND_OFFER);
        it.addr   = '1;
        it.server = '0;
        send_item(it);
        it        = reply_item(1'b1, xid_q[0], dcle_pkg::KIND_OFFER);
        it.addr   = '0;
        it.server = '1;
        send_item(it);
        send_item(tick_item());

        // Bind with extreme masks, one lease gone at once, one endless
        it        = reply_item(1'b1, xid_q[NSLOTS - 1], dcle_pkg::KIND_ACK);
        it.addr   = '1;
        it.mask   = '0;
        it.router = '1;
        it.dns    = '0;
        it.lease  = '0;
        send_item(it);
        it        = reply_item(1'b1, xid_q[0], dcle_pkg::KIND_ACK);
        it.addr   = 32'hC0A8_0164;
        it.mask   = '1;
        it.router = '0;
        it.dns    = '1;
        it.lease  = '1;
        send_item(it);
        it        = reply_item(1'b1, xid_q[3], dcle_pkg::KIND_ACK);
        it.mask   = 32'hFFFF_FF00;
        send_item(it);

        send_item(reply_item(1'b1, xid_q[4], dcle_pkg::KIND_OTHER));
        send_item(reply_item(1'b0, xid_q[4], dcle_pkg::KIND_OFFER));
        send_item(reply_item(1'b1, xid_q[5], dcle_pkg::KIND_NAK));
        stale_xid = xid_q[NSLOTS - 1];
        send_item(tick_item());

        // Pause until the table has reported everything
        wait_drained();
        send_item(reply_item(1'b1, stale_xid, dcle_pkg::KIND_OFFER));
        send_item(reply_item(1'b1, xid_q[0], dcle_pkg::KIND_NAK));
        send_item(tick_item());
    endtask

    // Mostly well-formed client flows with random content, some noise
    task automatic test_random_traffic(input int count);
        dcle_pkg::t_item it;
        int              done;
        int              pick;
        int              s;
        done = 0;
        while (done < count) begin
            // Alternate stretches with and without idling
            idle_en = ((done / 80) % 3) != 1;
            pick    = $urandom_range(99, 0);
            s       = $urandom_range(NSLOTS - 1, 0);
            if (pick < 40 || (pick < 75 && !used_q[s])) begin
                it = tick_item();
            end else if (pick < 75) begin
                it = reply_item(1'b1, xid_q[s], 2'($urandom_range(3, 0)));
                // Steer the task along its flow most of the time
                if ($urandom_range(9, 0) < 7) begin
                    if (phase_q[s] == dcle_pkg::PH_DISCOVER) it.kind = dcle_pkg::KIND_OFFER;
                    else if (phase_q[s] == dcle_pkg::PH_REQUEST) it.kind = dcle_pkg::KIND_ACK;
                end
                if ($urandom_range(1, 0) == 1) it.mask = ~32'h0 << $urandom_range(32, 0);
                if ($urandom_range(15, 0) == 0) it.lease = $urandom;
            end else if (pick < 80) begin
                it = add_item({16'($urandom), 32'($urandom)});
            end else begin
                // Noise: non-boot, unknown identifier or unused command
                it = rand_item();
                case ($urandom_range(2, 0))
                    0: begin
                        it.cmd     = dcle_pkg::CMD_REPLY;
                        it.is_boot = 1'b0;
                        if (used_q[s]) it.xid = xid_q[s];
                    end
                    1: begin
                        it.cmd     = dcle_pkg::CMD_REPLY;
                        it.is_boot = 1'b1;
                    end
                    default: it.cmd = CMD_UNUSED;
                endcase
                noise_sent++;
            end
            send_item(it);
            done++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        drv          = '0;
        idle_en      = 1'b1;
        ready_wait   = 0;
        mismatches   = 0;
        cmds_sent    = 0;
        noise_sent   = 0;
        results_seen = 0;
        kind_seen    = '{default: 0};
        xid_next     = dcle_pkg::XID_START;
        for (int i = 0; i < NSLOTS; i++) begin
            used_q[i]  = 1'b0;
            phase_q[i] = dcle_pkg::PH_DISCOVER;
            cnt_q[i]   = '0;
            xid_q[i]   = '0;
            mac_q[i]   = '0;
            offer_q[i] = '0;
            srv_q[i]   = '0;
            age_q[i]   = 0;
        end

        // Hold reset, release at a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_fill_table();
        test_discovery_ticks();
        test_reply_kinds();
        test_random_traffic(440);

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        mismatches += lease_msgs_q.size();

        $display("Sent %0d commands (%0d noise); checked %0d results", cmds_sent,
                 noise_sent, results_seen);
        $display("  discover %0d, request %0d, bound %0d, add outcome %0d",
                 kind_seen[dcle_pkg::RES_DISCOVER], kind_seen[dcle_pkg::RES_REQUEST],
                 kind_seen[dcle_pkg::RES_BOUND], kind_seen[dcle_pkg::RES_ADD]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

### dhcp_client_lease_engine.f
design/dcle_pkg.sv
design/dcle_slot_unit.sv
design/dhcp_client_lease_engine.sv
sim/dhcp_client_lease_engine_tb.sv
